@@ design/sssp_pkg.sv @@
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared types and constants for the single-source shortest path engine.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int VTX_BITS  = 5;   // vertex field width on the stream ports
  localparam int DIST_BITS = 22;  // reported distance width
  localparam int CNT_BITS  = 6;   // vertex count register width
  localparam int IN_WIDTH_BITS = 16; // edge weight field width on the input

  localparam logic [DIST_BITS-1:0] DIST_MAX  = {DIST_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0]  CNT_RESET = 6'd32;

  localparam int DEF_MAX_VERTICES     = 32;
  localparam int DEF_MAX_EDGE_ENTRIES = 256;
  localparam int DEF_WEIGHT_BITS      = 16;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_RUN = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD2,
    ST_INIT,
    ST_SRC,
    ST_SEL,
    ST_SETTLE,
    ST_RELAX,
    ST_ORD,
    ST_OLOAD,
    ST_OSEND
  } state_e;

  // one distance table entry
  typedef struct packed {
    logic                 settled;
    logic                 inf;
    logic [DIST_BITS-1:0] path_len;
  } dist_ent_t;

endpackage

@@ design/single_source_shortest_path.sv @@
// ----------------------------------------------------------------------------
// single_source_shortest_path
// Undirected weighted graph store with a Dijkstra distance engine.
// ----------------------------------------------------------------------------
// An add transaction (tuser = 0) stores the edge in both directions in the edge
// memory; when the memory lacks two free entries the edge is dropped and a
// sticky overflow flag is set. A run transaction (tuser = 1) clears the
// distance memory and seeds the source. Then, once per reachable vertex, a
// minimum search over the distance memory is followed by settling the winner
// and a relaxation scan over all stored edge entries; a closing search that
// finds nothing ends the search phase. Finally one result per vertex is
// streamed in index order, each held until m_axis_tready takes it. The edge
// memory scan, one entry per cycle, dominates the run time. No input is taken
// while a run is in flight.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
  parameter int MAX_VERTICES     = sssp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGE_ENTRIES = sssp_pkg::DEF_MAX_EDGE_ENTRIES,
  parameter int WEIGHT_BITS      = sssp_pkg::DEF_WEIGHT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // vertex count register
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // from_vertex[4:0], to_vertex[9:5], edge_weight[25:10]
  input  logic        s_axis_tuser,   // operation
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // vertex_index[4:0], path_distance[26:5],
                                      // reachable[27], edge_overflow[28]
  output logic        m_axis_tlast
);

  localparam int VB   = sssp_pkg::VTX_BITS;
  localparam int DB   = sssp_pkg::DIST_BITS;
  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int CW   = ((NW > VB) ? NW : VB) + 1;
  localparam int EW   = $clog2(MAX_EDGE_ENTRIES);
  localparam int ECW  = $clog2(MAX_EDGE_ENTRIES + 1);
  localparam int EDW  = 2 * VB + WEIGHT_BITS;
  localparam int SUMW = ((WEIGHT_BITS > DB) ? WEIGHT_BITS : DB) + 1;

  // memories
  logic [EDW-1:0]           edge_mem [MAX_EDGE_ENTRIES];
  sssp_pkg::dist_ent_t      dist_mem [MAX_VERTICES];

  sssp_pkg::state_e         state_q, state_d;
  logic [sssp_pkg::CNT_BITS-1:0] cnt_q;
  logic [ECW-1:0]           ecnt_q, ecnt_d;
  logic                     ovf_q, ovf_d;
  logic [NW-1:0]            n_q, n_d, act_n;
  logic [VB-1:0]            src_q, src_d;
  logic [NW-1:0]            v_q, v_d;
  logic [ECW-1:0]           e_q, e_d;
  logic [VW-1:0]            best_q, best_d;
  logic [DB-1:0]            best_dist_q, best_dist_d;
  logic                     found_q, found_d;
  logic                     sel_vld_q, sel_vld_d;
  logic [VW-1:0]            sel_v_q, sel_v_d;
  logic                     b_vld_q, b_vld_d;
  logic                     c_vld_q, c_vld_d;
  logic [VW-1:0]            c_tgt_q, c_tgt_d;
  logic [WEIGHT_BITS-1:0]   c_w_q, c_w_d;
  logic                     lw_vld_q, lw_vld_d;
  logic [VW-1:0]            lw_addr_q;
  sssp_pkg::dist_ent_t      lw_data_q;
  logic [VB-1:0]            add_a_q, add_b_q;
  logic [WEIGHT_BITS-1:0]   add_w_q;
  logic                     m_vld_q, m_vld_d;
  logic [VB-1:0]            o_vtx_q;
  logic [DB-1:0]            o_dist_q;
  logic                     o_reach_q, o_ovf_q, o_last_q;

  logic [EDW-1:0]           edge_rd_q;
  sssp_pkg::dist_ent_t      dist_rd_q;

  logic                     edge_we;
  logic [EW-1:0]            edge_waddr, edge_raddr;
  logic [EDW-1:0]           edge_wdata;
  logic                     dist_we;
  logic [VW-1:0]            dist_waddr, dist_raddr;
  sssp_pkg::dist_ent_t      dist_wdata;

  logic                     in_fire, out_fire;
  logic [VB-1:0]            in_a, in_b;
  logic [WEIGHT_BITS-1:0]   in_w;
  logic                     add_full;
  logic                     sel_done, relax_done, src_ok;
  logic [VB-1:0]            er_src, er_tgt;
  logic [WEIGHT_BITS-1:0]   er_w;
  logic                     edge_hit;
  sssp_pkg::dist_ent_t      cur_ent;
  logic [SUMW-1:0]          cand_sum;
  logic [DB-1:0]            cand;
  logic                     relax_wr;
  logic                     sel_take;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign in_a     = s_axis_tdata[4:0];
  assign in_b     = s_axis_tdata[9:5];
  assign in_w     = WEIGHT_BITS'({16'd0, s_axis_tdata[25:10]});

  assign add_full = ({1'b0, ecnt_q} + (ECW + 1)'(2)) > (ECW + 1)'(MAX_EDGE_ENTRIES);

  // count register clamped to 1..MAX_VERTICES
  always_comb begin
    if (cnt_q == '0) begin
      act_n = NW'(1);
    end else if (CW'(cnt_q) > CW'(MAX_VERTICES)) begin
      act_n = NW'(MAX_VERTICES);
    end else begin
      act_n = NW'(cnt_q);
    end
  end

  assign src_ok = CW'(src_q) < CW'(n_q);

  // minimum search
  assign sel_take = sel_vld_q && !dist_rd_q.settled && !dist_rd_q.inf &&
                    (!found_q || (dist_rd_q.path_len < best_dist_q));
  assign sel_done = (v_q == n_q) && !sel_vld_q;

  // relaxation pipeline: edge read, distance read, compare and write back
  assign er_src   = edge_rd_q[VB-1:0];
  assign er_tgt   = edge_rd_q[2*VB-1:VB];
  assign er_w     = edge_rd_q[EDW-1:2*VB];
  assign edge_hit = b_vld_q && (CW'(er_src) == CW'(best_q)) && (CW'(er_tgt) < CW'(n_q));
  assign cur_ent  = (lw_vld_q && (lw_addr_q == c_tgt_q)) ? lw_data_q : dist_rd_q;
  assign cand_sum = SUMW'(best_dist_q) + SUMW'(c_w_q);
  assign cand     = (cand_sum > SUMW'(sssp_pkg::DIST_MAX)) ? sssp_pkg::DIST_MAX
                                                           : cand_sum[DB-1:0];
  assign relax_wr = (state_q == sssp_pkg::ST_RELAX) && c_vld_q &&
                    (cur_ent.inf || (cand < cur_ent.path_len));
  assign relax_done = (e_q == ecnt_q) && !b_vld_q && !c_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sssp_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser == sssp_pkg::OP_RUN) begin
            state_d = sssp_pkg::ST_INIT;
          end else if (!add_full) begin
            state_d = sssp_pkg::ST_ADD2;
          end
        end
      end
      sssp_pkg::ST_ADD2:   state_d = sssp_pkg::ST_IDLE;
      sssp_pkg::ST_INIT: begin
        if (v_q == n_q - NW'(1)) state_d = sssp_pkg::ST_SRC;
      end
      sssp_pkg::ST_SRC:    state_d = sssp_pkg::ST_SEL;
      sssp_pkg::ST_SEL: begin
        if (sel_done) state_d = found_q ? sssp_pkg::ST_SETTLE : sssp_pkg::ST_ORD;
      end
      sssp_pkg::ST_SETTLE: state_d = sssp_pkg::ST_RELAX;
      sssp_pkg::ST_RELAX: begin
        if (relax_done) state_d = sssp_pkg::ST_SEL;
      end
      sssp_pkg::ST_ORD:    state_d = sssp_pkg::ST_OLOAD;
      sssp_pkg::ST_OLOAD:  state_d = sssp_pkg::ST_OSEND;
      sssp_pkg::ST_OSEND: begin
        if (out_fire) state_d = o_last_q ? sssp_pkg::ST_IDLE : sssp_pkg::ST_ORD;
      end
      default:             state_d = sssp_pkg::ST_IDLE;
    endcase
  end

  // datapath control and memory ports
  always_comb begin
    ecnt_d      = ecnt_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    src_d       = src_q;
    v_d         = v_q;
    e_d         = e_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    found_d     = found_q;
    sel_vld_d   = 1'b0;
    sel_v_d     = sel_v_q;
    b_vld_d     = 1'b0;
    c_vld_d     = 1'b0;
    c_tgt_d     = c_tgt_q;
    c_w_d       = c_w_q;
    lw_vld_d    = relax_wr;
    m_vld_d     = m_vld_q;
    s_axis_tready = 1'b0;

    edge_we     = 1'b0;
    edge_waddr  = ecnt_q[EW-1:0];
    edge_wdata  = {in_w, in_b, in_a};
    edge_raddr  = '0;
    dist_we     = 1'b0;
    dist_waddr  = v_q[VW-1:0];
    dist_wdata  = '{settled: 1'b0, inf: 1'b1, path_len: '0};
    dist_raddr  = v_q[VW-1:0];

    case (state_q)
      sssp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          if (s_axis_tuser == sssp_pkg::OP_RUN) begin
            n_d   = act_n;
            src_d = in_a;
            v_d   = '0;
          end else if (add_full) begin
            ovf_d = 1'b1;
          end else begin
            edge_we = 1'b1;
            ecnt_d  = ecnt_q + ECW'(1);
          end
        end
      end
      sssp_pkg::ST_ADD2: begin
        edge_we    = 1'b1;
        edge_wdata = {add_w_q, add_a_q, add_b_q};
        ecnt_d     = ecnt_q + ECW'(1);
      end
      sssp_pkg::ST_INIT: begin
        dist_we = 1'b1;
        v_d     = v_q + NW'(1);
      end
      sssp_pkg::ST_SRC: begin
        dist_we    = src_ok;
        dist_waddr = VW'(src_q);
        dist_wdata = '{settled: 1'b0, inf: 1'b0, path_len: '0};
        v_d        = '0;
        found_d    = 1'b0;
      end
      sssp_pkg::ST_SEL: begin
        if (v_q != n_q) begin
          sel_vld_d = 1'b1;
          sel_v_d   = v_q[VW-1:0];
          v_d       = v_q + NW'(1);
        end
        if (sel_take) begin
          best_d      = sel_v_q;
          best_dist_d = dist_rd_q.path_len;
          found_d     = 1'b1;
        end
        if (sel_done) v_d = '0;
      end
      sssp_pkg::ST_SETTLE: begin
        dist_we    = 1'b1;
        dist_waddr = best_q;
        dist_wdata = '{settled: 1'b1, inf: 1'b0, path_len: best_dist_q};
        e_d        = '0;
        lw_vld_d   = 1'b0;
      end
      sssp_pkg::ST_RELAX: begin
        if (e_q != ecnt_q) begin
          edge_raddr = e_q[EW-1:0];
          b_vld_d    = 1'b1;
          e_d        = e_q + ECW'(1);
        end
        c_vld_d    = edge_hit;
        c_tgt_d    = VW'(er_tgt);
        c_w_d      = er_w;
        dist_raddr = VW'(er_tgt);
        dist_we    = relax_wr;
        dist_waddr = c_tgt_q;
        dist_wdata = '{settled: cur_ent.settled, inf: 1'b0, path_len: cand};
        if (relax_done) begin
          v_d     = '0;
          found_d = 1'b0;
        end
      end
      sssp_pkg::ST_ORD: begin
      end
      sssp_pkg::ST_OLOAD: begin
        m_vld_d = 1'b1;
      end
      sssp_pkg::ST_OSEND: begin
        if (out_fire) begin
          m_vld_d = 1'b0;
          v_d     = v_q + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sssp_pkg::ST_IDLE;
      cnt_q     <= sssp_pkg::CNT_RESET;
      ecnt_q    <= '0;
      ovf_q     <= 1'b0;
      sel_vld_q <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      lw_vld_q  <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_wr_en_i) cnt_q <= cfg_wr_data_i;
      ecnt_q    <= ecnt_d;
      ovf_q     <= ovf_d;
      sel_vld_q <= sel_vld_d;
      b_vld_q   <= b_vld_d;
      c_vld_q   <= c_vld_d;
      lw_vld_q  <= lw_vld_d;
      m_vld_q   <= m_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    src_q       <= src_d;
    v_q         <= v_d;
    e_q         <= e_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    found_q     <= found_d;
    sel_v_q     <= sel_v_d;
    c_tgt_q     <= c_tgt_d;
    c_w_q       <= c_w_d;
    lw_addr_q   <= dist_waddr;
    lw_data_q   <= dist_wdata;
    if (in_fire) begin
      add_a_q <= in_a;
      add_b_q <= in_b;
      add_w_q <= in_w;
    end
    if (state_q == sssp_pkg::ST_OLOAD) begin
      o_vtx_q   <= VB'(v_q);
      o_dist_q  <= dist_rd_q.inf ? '0 : dist_rd_q.path_len;
      o_reach_q <= !dist_rd_q.inf;
      o_ovf_q   <= ovf_q;
      o_last_q  <= (v_q == n_q - NW'(1));
    end
  end

  // edge memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rd_q <= edge_mem[edge_raddr];
  end

  // distance memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rd_q <= dist_mem[dist_raddr];
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {3'd0, o_ovf_q, o_reach_q, o_dist_q, o_vtx_q};
  assign m_axis_tlast  = o_last_q;

endmodule

@@ design/sssp_chk.sv @@
// ----------------------------------------------------------------------------
// sssp_chk
// Port-level checks for the shortest path engine, bound to the top level.
// ----------------------------------------------------------------------------
module sssp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // input is only taken while no result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == sssp_pkg::OP_RUN) |=>
      !s_axis_tready)
    else $error("run transaction did not make the block busy");

  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("block went idle before the last result");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after the last result");

endmodule

bind single_source_shortest_path sssp_chk u_sssp_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_single_source_shortest_path.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_single_source_shortest_path
// Self-checking bench for the graph store and shortest-distance engine.
// ----------------------------------------------------------------------------
// A directed table covers the empty graph, weight and vertex extremes, self
// loops, sources at or past the vertex count and the out-of-range counts.
// Random phases at several vertex counts follow, closed by one more run.
// Each result is checked against a local distance predictor or a typed row's own
// expectation; both sides idle at random, the result side once for a long stretch.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_path;

  localparam int          NUM_VTX     = sssp_pkg::DEF_MAX_VERTICES;
  localparam int          NUM_ENTRIES = sssp_pkg::DEF_MAX_EDGE_ENTRIES;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          RAND_PHASES = 7;
  localparam int          PHASE_ITEMS = 11;
  localparam int unsigned DIST_SAT    = 32'd4194303;

  typedef enum logic [1:0] {
    SK_ADD,
    SK_RUN,
    SK_CFG
  } step_kind_e;

  // one row of the directed table; typed rows carry their own expectation:
  // reach_mask marks the reachable vertices, all at distance zero
  typedef struct packed {
    step_kind_e                    kind;
    logic [sssp_pkg::VTX_BITS-1:0] a;
    logic [sssp_pkg::VTX_BITS-1:0] b;
    logic [15:0]                   w;
    logic [sssp_pkg::CNT_BITS-1:0] cnt;
    logic                          typed;
    logic [31:0]                   reach_mask;
  } step_t;

  typedef struct packed {
    logic [sssp_pkg::VTX_BITS-1:0]  vtx;
    logic [sssp_pkg::DIST_BITS-1:0] path_len;
    logic                           reach;
    logic                           ovf;
    logic                           last;
  } vtx_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [5:0]  cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  single_source_shortest_path uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // predictor copy of the graph and the count register
  logic [sssp_pkg::VTX_BITS-1:0] graph_src [NUM_ENTRIES];
  logic [sssp_pkg::VTX_BITS-1:0] graph_dst [NUM_ENTRIES];
  logic [15:0]                   graph_wgt [NUM_ENTRIES];
  int unsigned                   graph_entries = 0;
  bit                            graph_ovf     = 1'b0;
  logic [sssp_pkg::CNT_BITS-1:0] pred_count    = sssp_pkg::CNT_RESET;

  vtx_result_t pending_dists [$];
  int unsigned error_cnt = 0;
  bit          hold_req  = 1'b0;
  bit          src_burst = 1'b0;

  step_t plan [25] = '{
    '{SK_RUN,  5'd0,  5'd0, 16'h0000, 6'd0,  1'b1, 32'h0000_0001},
    '{SK_RUN,  5'd31, 5'd0, 16'h0000, 6'd0,  1'b1, 32'h8000_0000},
    '{SK_ADD,  5'd0,  5'd31, 16'hFFFF, 6'd0, 1'b0, 32'h0},
    '{SK_ADD,  5'd31, 5'd31, 16'h0000, 6'd0, 1'b0, 32'h0},
    '{SK_ADD,  5'd0,  5'd1, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_ADD,  5'd1,  5'd2, 16'h0001, 6'd0,  1'b0, 32'h0},
    '{SK_ADD,  5'd2,  5'd31, 16'hAAAA, 6'd0, 1'b0, 32'h0},
    '{SK_ADD,  5'd0,  5'd2, 16'h5555, 6'd0,  1'b0, 32'h0},
    '{SK_RUN,  5'd0,  5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_RUN,  5'd31, 5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_ADD,  5'd5,  5'd5, 16'hFFFF, 6'd0,  1'b0, 32'h0},
    '{SK_RUN,  5'd5,  5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_CFG,  5'd0,  5'd0, 16'h0000, 6'd4,  1'b0, 32'h0},
    // source at or past the count: nothing reachable
    '{SK_RUN,  5'd20, 5'd0, 16'h0000, 6'd0,  1'b1, 32'h0},
    '{SK_RUN,  5'd31, 5'd31, 16'hFFFF, 6'd0, 1'b1, 32'h0},
    '{SK_ADD,  5'd3,  5'd30, 16'h0007, 6'd0, 1'b0, 32'h0},
    '{SK_RUN,  5'd0,  5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    // count 0 behaves as 1
    '{SK_CFG,  5'd0,  5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_RUN,  5'd0,  5'd17, 16'h1234, 6'd0, 1'b1, 32'h0000_0001},
    '{SK_RUN,  5'd1,  5'd0, 16'h0000, 6'd0,  1'b1, 32'h0},
    // count above the maximum behaves as the maximum
    '{SK_CFG,  5'd0,  5'd0, 16'h0000, 6'd63, 1'b0, 32'h0},
    '{SK_RUN,  5'd2,  5'd0, 16'h0000, 6'd0,  1'b0, 32'h0},
    '{SK_CFG,  5'd0,  5'd0, 16'h0000, 6'd32, 1'b0, 32'h0},
    '{SK_ADD,  5'd10, 5'd11, 16'h8000, 6'd0, 1'b0, 32'h0},
    '{SK_RUN,  5'd10, 5'd0, 16'h0000, 6'd0,  1'b0, 32'h0}
  };

  function automatic int unsigned active_vertices(logic [sssp_pkg::CNT_BITS-1:0] c);
    if (c == '0) return 1;
    if (c > NUM_VTX) return NUM_VTX;
    return c;
  endfunction

  function automatic void store_edge(logic [sssp_pkg::VTX_BITS-1:0] a,
                                     logic [sssp_pkg::VTX_BITS-1:0] b,
                                     logic [15:0] w);
    if (graph_entries + 2 > NUM_ENTRIES) begin
      graph_ovf = 1'b1;
      return;
    end
    graph_src[graph_entries] = a;
    graph_dst[graph_entries] = b;
    graph_wgt[graph_entries] = w;
    graph_src[graph_entries + 1] = b;
    graph_dst[graph_entries + 1] = a;
    graph_wgt[graph_entries + 1] = w;
    graph_entries += 2;
  endfunction

  // Dijkstra by array scan; ties settle the lowest index first
  function automatic void shortest_paths(logic [sssp_pkg::VTX_BITS-1:0] src);
    int unsigned span [NUM_VTX];
    bit          unreached [NUM_VTX];
    bit          settled [NUM_VTX];
    int unsigned n, best, cand;
    vtx_result_t r;
    n = active_vertices(pred_count);
    for (int v = 0; v < NUM_VTX; v++) begin
      span[v] = 0;
      unreached[v] = 1'b1;
      settled[v] = 1'b0;
    end
    if (src < n) begin
      span[src] = 0;
      unreached[src] = 1'b0;
      for (int round = 0; round < n; round++) begin
        best = n;
        for (int v = 0; v < n; v++) begin
          if (!settled[v] && !unreached[v] && (best == n || span[v] < span[best]))
            best = v;
        end
        if (best == n) break;
        settled[best] = 1'b1;
        for (int e = 0; e < graph_entries; e++) begin
          if (graph_src[e] == best && graph_dst[e] < n) begin
            cand = span[best] + graph_wgt[e];
            if (cand > DIST_SAT) cand = DIST_SAT;
            if (unreached[graph_dst[e]] || cand < span[graph_dst[e]]) begin
              span[graph_dst[e]] = cand;
              unreached[graph_dst[e]] = 1'b0;
            end
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vtx      = v[sssp_pkg::VTX_BITS-1:0];
      r.path_len = unreached[v] ? '0 : span[v][sssp_pkg::DIST_BITS-1:0];
      r.reach    = !unreached[v];
      r.ovf      = graph_ovf;
      r.last     = (v + 1 == n);
      pending_dists = {pending_dists, r};
    end
  endfunction

  // expectation read straight off a directed row
  function automatic void typed_dists(logic [31:0] reach_mask);
    int unsigned n;
    vtx_result_t r;
    n = active_vertices(pred_count);
    for (int v = 0; v < n; v++) begin
      r.vtx      = v[sssp_pkg::VTX_BITS-1:0];
      r.path_len = '0;
      r.reach    = reach_mask[v];
      r.ovf      = 1'b0;
      r.last     = (v + 1 == n);
      pending_dists = {pending_dists, r};
    end
  endfunction

  // entered and left at a falling edge
  task automatic push_item(sssp_pkg::op_e op, logic [sssp_pkg::VTX_BITS-1:0] a,
                           logic [sssp_pkg::VTX_BITS-1:0] b, logic [15:0] w,
                           bit typed, logic [31:0] reach_mask);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, w, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == sssp_pkg::OP_ADD) store_edge(a, b, w);
    else if (typed) typed_dists(reach_mask);
    else shortest_paths(a);
    @(negedge clk_i);
  endtask

  // wait for every result, then give a trailing add time to land
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_dists.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_count(logic [sssp_pkg::CNT_BITS-1:0] c);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= c;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    pred_count = c;
  endtask

  function automatic logic [sssp_pkg::VTX_BITS-1:0] pick_vertex(int unsigned n);
    int unsigned v;
    if ($urandom_range(0, 4) == 0) v = $urandom_range(0, NUM_VTX - 1);
    else v = $urandom_range(0, n - 1);
    return v[sssp_pkg::VTX_BITS-1:0];
  endfunction

  function automatic logic [15:0] pick_weight();
    int unsigned w;
    case ($urandom_range(0, 4))
      0, 1: w = $urandom_range(0, 7);   // small weights give ties
      2:    w = ($urandom_range(0, 1) == 1) ? 32'hFFFF : 32'h0000;
      default: w = $urandom_range(0, 16'hFFFF);
    endcase
    return w[15:0];
  endfunction

  task automatic random_item(int unsigned n);
    if ($urandom_range(0, 3) == 0) begin
      push_item(sssp_pkg::OP_RUN, pick_vertex(n), pick_vertex(NUM_VTX), pick_weight(),
                1'b0, '0);
    end else begin
      push_item(sssp_pkg::OP_ADD, pick_vertex(n), pick_vertex(n), pick_weight(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [sssp_pkg::CNT_BITS-1:0] phase_counts [RAND_PHASES];
    int unsigned n;
    phase_counts = '{6'd32, 6'd1, 6'd2, 6'd0, 6'd63, 6'd7, 6'd32};
    n = $urandom_range(1, NUM_VTX);
    phase_counts[RAND_PHASES-1] = n[sssp_pkg::CNT_BITS-1:0];
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        SK_CFG: begin
          settle_block();
          write_count(plan[i].cnt);
        end
        SK_ADD: push_item(sssp_pkg::OP_ADD, plan[i].a, plan[i].b, plan[i].w, 1'b0, '0);
        default: push_item(sssp_pkg::OP_RUN, plan[i].a, plan[i].b, plan[i].w,
                           plan[i].typed, plan[i].reach_mask);
      endcase
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_block();
      write_count(phase_counts[p]);
      if (p == 0) hold_req = 1'b1;
      src_burst = ($urandom_range(0, 3) == 0);
      n = active_vertices(pred_count);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(n);
    end

    // one last run over the whole graph
    settle_block();
    write_count(6'd32);
    src_burst = 1'b0;
    push_item(sssp_pkg::OP_RUN, 5'd0, 5'd0, 16'h0, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    while (pending_dists.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (error_cnt == 0 && pending_dists.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    bit          rcv_burst;
    bit          prev_last;
    vtx_result_t want;
    rcv_burst = 1'b0;
    prev_last = 1'b1;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 24) == 0) rcv_burst = !rcv_burst;
      stall = rcv_burst ? 0 : $urandom_range(0, 13);
      // long hold in the middle of a run so the engine backs up
      if (hold_req && !prev_last) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      prev_last = m_axis_tlast;
      if (pending_dists.size() == 0) begin
        $error("unexpected result transaction for vertex %0d", m_axis_tdata[4:0]);
        error_cnt++;
      end else begin
        want = pending_dists.pop_front();
        if (m_axis_tdata[4:0] !== want.vtx) begin
          $error("vertex_index: expected %0d, got %0d", want.vtx, m_axis_tdata[4:0]);
          error_cnt++;
        end
        if (m_axis_tdata[26:5] !== want.path_len) begin
          $error("path_distance: expected %0d, got %0d", want.path_len,
                 m_axis_tdata[26:5]);
          error_cnt++;
        end
        if (m_axis_tdata[27] !== want.reach) begin
          $error("reachable: expected %0d, got %0d", want.reach, m_axis_tdata[27]);
          error_cnt++;
        end
        if (m_axis_tdata[28] !== want.ovf) begin
          $error("edge_overflow: expected %0d, got %0d", want.ovf, m_axis_tdata[28]);
          error_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          error_cnt++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
